[rtl/rba_pkg.sv]
`timescale 1ns / 1ps
package rba_pkg;

  localparam logic [31:0] RESET_FREE  = 32'h0020_2000;
  localparam logic [3:0]  KIND_USABLE = 4'h1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  localparam logic [1:0] RES_OK    = 2'd0;
  localparam logic [1:0] RES_NOFIT = 2'd1;
  localparam logic [1:0] RES_WIDE  = 2'd2;

  localparam int COUNT_W = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } rba_state_t;

  typedef struct packed {
    logic        wide;
    logic [3:0]  kind;
    logic [31:0] length;
    logic [31:0] base;
  } rba_entry_t;

  typedef struct packed {
    logic load;
    logic start;
    logic prep;
    logic issue;
    logic take_hit;
    logic nofit;
    logic push;
  } rba_cmd_t;

  typedef struct packed {
    logic hit;
    logic done;
    logic empty;
    logic last_issue;
    logic out_free;
  } rba_stat_t;

endpackage

[rtl/rba_ram.sv]
`timescale 1ns / 1ps
module rba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/rba_ctrl.sv]
`timescale 1ns / 1ps
module rba_ctrl
  import rba_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic      req_type,
  input  rba_stat_t st,
  output rba_cmd_t  cmd
);

  rba_state_t state;
  rba_state_t state_next;
  logic       accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req_type == REQ_LOAD) ? ST_RESULT : ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = st.empty ? ST_RESULT : ST_SCAN;
      end
      ST_SCAN: begin
        if (st.hit) begin
          state_next = ST_RESULT;
        end else if (st.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (st.hit || st.done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (st.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load  = accept && (req_type == REQ_LOAD);
        cmd.start = accept && (req_type == REQ_ALLOC);
      end
      ST_PREP: begin
        cmd.nofit = st.empty;
        cmd.prep  = !st.empty;
      end
      ST_SCAN: begin
        cmd.take_hit = st.hit;
        cmd.issue    = !st.hit;
      end
      ST_DRAIN: begin
        cmd.take_hit = st.hit;
        cmd.nofit    = !st.hit && st.done;
      end
      ST_RESULT: begin
        cmd.push = st.out_free;
      end
      default: cmd = '0;
    endcase
  end

  a_hit_ends_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_SCAN || state == ST_DRAIN) && st.hit) |=> (state == ST_RESULT))
    else $error("scan went on after a deciding entry");

  a_push_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> st.out_free)
    else $error("result pushed over an unread beat");

endmodule

[rtl/rba_dp.sv]
`timescale 1ns / 1ps
module rba_dp
  import rba_pkg::*;
#(
  parameter int MAX_REGIONS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rba_cmd_t             cmd,
  output rba_stat_t            st,
  input  logic                 cfg_valid,
  input  logic [COUNT_W-1:0]   cfg_data,
  input  logic [3:0]           region_index,
  input  logic [31:0]          region_start,
  input  logic [31:0]          region_length,
  input  logic [3:0]           region_kind,
  input  logic                 region_wide,
  input  logic [31:0]          alloc_size,
  input  logic [31:0]          alloc_align,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [1:0]           res_status_out,
  output logic [31:0]          res_addr_out
);

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int ENT_W = $bits(rba_entry_t);

  logic [COUNT_W-1:0] region_count;
  logic [31:0]        next_free;
  logic [31:0]        align_mask;
  logic [31:0]        req_size;
  logic [31:0]        cand;
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   idx_cnt;
  logic [CNT_W-1:0]   idx_inc;

  logic               rd_v;
  logic               rd_last;
  logic               p1_v;
  logic               p1_last;
  logic               p1_usable;
  logic               p1_wide;
  logic [31:0]        p1_ab;
  logic [31:0]        p1_end;
  logic               p1_gt;

  logic [1:0]         res_status;
  logic [31:0]        res_addr;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  rba_entry_t         wr_entry;
  logic [ENT_W-1:0]   rd_bits;
  rba_entry_t         rd_entry;

  logic [31:0]        eval_cand;
  logic [31:0]        eval_sum;
  logic               eval_fit;
  logic               kill;

  assign wr_en    = cmd.load && (32'(region_index) < 32'(MAX_REGIONS));
  assign wr_addr  = IDX_W'(region_index);
  assign wr_entry = '{wide: region_wide, kind: region_kind,
                      length: region_length, base: region_start};
  assign rd_entry = rba_entry_t'(rd_bits);

  rba_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_REGIONS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .raddr (idx_cnt[IDX_W-1:0]),
    .rdata (rd_bits)
  );

  assign idx_inc   = idx_cnt + CNT_W'(1);
  assign kill      = cmd.take_hit || cmd.nofit;

  // second scan stage: pick candidate, add size, test against region end
  assign eval_cand = p1_gt ? p1_ab : cand;
  assign eval_sum  = eval_cand + req_size;
  assign eval_fit  = (p1_end >= eval_sum);

  assign st.hit        = p1_v && p1_usable && (p1_wide || eval_fit);
  assign st.done       = p1_v && p1_last;
  assign st.empty      = (region_count == '0);
  assign st.last_issue = (idx_inc == limit);
  assign st.out_free   = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= '0;
    end else if (cfg_valid) begin
      region_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_free <= RESET_FREE;
    end else if (cmd.take_hit && !p1_wide) begin
      next_free <= eval_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      align_mask <= alloc_align - 32'd1;
      req_size   <= alloc_size;
      if (32'(region_count) >= 32'(MAX_REGIONS)) begin
        limit <= CNT_W'(MAX_REGIONS);
      end else begin
        limit <= CNT_W'(region_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      cand <= (next_free + align_mask) & ~align_mask;
    end else if (p1_v && p1_usable && !p1_wide) begin
      cand <= eval_cand;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      idx_cnt <= '0;
    end else if (cmd.issue) begin
      idx_cnt <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      p1_v <= 1'b0;
    end else begin
      rd_v <= cmd.issue;
      p1_v <= rd_v && !kill;
    end
  end

  // first scan stage: aligned base, end address and base compare
  always_ff @(posedge clk) begin
    rd_last   <= st.last_issue;
    p1_last   <= rd_last;
    p1_usable <= (rd_entry.kind == KIND_USABLE);
    p1_wide   <= rd_entry.wide;
    p1_ab     <= (rd_entry.base + align_mask) & ~align_mask;
    p1_end    <= rd_entry.base + rd_entry.length;
    p1_gt     <= (rd_entry.base > next_free);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_status <= RES_OK;
      res_addr   <= '0;
    end else if (cmd.load) begin
      res_status <= RES_OK;
      res_addr   <= '0;
    end else if (cmd.nofit) begin
      res_status <= RES_NOFIT;
      res_addr   <= '0;
    end else if (cmd.take_hit) begin
      res_status <= p1_wide ? RES_WIDE : RES_OK;
      res_addr   <= p1_wide ? 32'd0 : eval_cand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      res_status_out <= res_status;
      res_addr_out   <= res_addr;
    end
  end

  a_hit_has_entry: assert property (@(posedge clk) disable iff (rst)
    cmd.take_hit |-> p1_v)
    else $error("hit taken with no entry in the scan stage");

  a_free_moves_on_hit: assert property (@(posedge clk) disable iff (rst)
    !cmd.take_hit |=> $stable(next_free))
    else $error("free pointer moved without an allocation");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_status_out != RES_OK) |-> (res_addr_out == 32'd0))
    else $error("failed allocation returned an address");

endmodule

[rtl/region_bump_allocator.sv]
`timescale 1ns / 1ps
// channel   dir  handshake             payload
// s_*       in   s_tvalid / s_tready   tuser req_type, tdata region and alloc fields
// m_*       out  m_tvalid / m_tready   tdata status, block_address
// cfg_*     in   cfg_valid / cfg_ready cfg_data region_count
//
// a load beat goes from accept to ST_RESULT and then into the output register as the result beat
// an allocate scans up to n = min(region_count, MAX_REGIONS) table entries, stopping
// early on a hit, and none when region_count is 0; the region table ram is read one entry per cycle
// synchronous reset sets the free pointer to 0x202000 and region_count to 0;
// the region table is not cleared
// one item at a time; a result waits in the output register while m_tready is low
module region_bump_allocator
  import rba_pkg::*;
#(
  parameter int MAX_REGIONS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [143:0] s_tdata,  // region_index, region_start, region_length,
                                 // region_kind, region_wide, alloc_size, alloc_align
  input  logic         s_tuser,  // req_type
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,  // status, block_address
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [4:0]   cfg_data
);

  rba_cmd_t    cmd;
  rba_stat_t   st;
  logic [1:0]  res_status;
  logic [31:0] res_addr;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {6'd0, res_addr, res_status};

  rba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_type (s_tuser),
    .st       (st),
    .cmd      (cmd)
  );

  rba_dp #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .region_index   (s_tdata[3:0]),
    .region_start   (s_tdata[35:4]),
    .region_length  (s_tdata[67:36]),
    .region_kind    (s_tdata[71:68]),
    .region_wide    (s_tdata[72]),
    .alloc_size     (s_tdata[104:73]),
    .alloc_align    (s_tdata[136:105]),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .res_status_out (res_status),
    .res_addr_out   (res_addr)
  );

endmodule

[test/region_bump_allocator_tb.sv]
`timescale 1ns / 1ps
module region_bump_allocator_tb;
  import rba_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int ITEM_TARGET = 550;
  localparam int CALM_AFTER = 470;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic        req;
    logic [3:0]  idx;
    logic [31:0] start;
    logic [31:0] len;
    logic [3:0]  kind;
    logic        wide;
    logic [31:0] size;
    logic [31:0] align;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
  } grant_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [39:0]  m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [4:0]   cfg_data = '0;

  region_bump_allocator #(.MAX_REGIONS(TABLE_DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // allocator mirror
  logic [31:0]        free_ptr;
  logic [COUNT_W-1:0] count_mirror;
  logic [31:0]        base_mem [TABLE_DEPTH];
  logic [31:0]        len_mem  [TABLE_DEPTH];
  logic [3:0]         kind_mem [TABLE_DEPTH];
  logic               wide_mem [TABLE_DEPTH];

  alloc_req_t request_queue[$];
  grant_t     grant_queue[$];
  alloc_req_t cur_req;
  int         send_gap = 0;
  int         stall_left = 0;
  int         mismatches = 0;
  int         issued = 0;
  bit         calm = 1'b0;
  bit         long_stall_req = 1'b0;
  bit         long_stall_done = 1'b0;

  function automatic logic [31:0] round_up(logic [31:0] x, logic [31:0] a);
    logic [31:0] m;
    m = a - 32'd1;
    return (x + m) & ~m;
  endfunction

  task automatic model_request(input alloc_req_t r);
    grant_t      g;
    logic [31:0] cand;
    logic [31:0] region_end;
    logic [31:0] need_end;
    int          n;
    g.status = RES_NOFIT;
    g.addr = '0;
    if (r.req == REQ_LOAD) begin
      base_mem[r.idx] = r.start;
      len_mem[r.idx] = r.len;
      kind_mem[r.idx] = r.kind;
      wide_mem[r.idx] = r.wide;
      g.status = RES_OK;
    end else begin
      cand = round_up(free_ptr, r.align);
      n = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_mirror);
      for (int i = 0; i < n; i++) begin
        if (kind_mem[i] != KIND_USABLE) continue;
        if (wide_mem[i]) begin
          g.status = RES_WIDE;
          break;
        end
        if (base_mem[i] > free_ptr) cand = round_up(base_mem[i], r.align);
        region_end = base_mem[i] + len_mem[i];
        need_end = cand + r.size;
        if (region_end < need_end) continue;
        free_ptr = need_end;
        g.addr = cand;
        g.status = RES_OK;
        break;
      end
    end
    grant_queue.push_back(g);
  endtask

  function automatic alloc_req_t load_item(logic [3:0] idx, logic [31:0] start,
                                           logic [31:0] len, logic [3:0] kind, logic wide);
    alloc_req_t r;
    r.req = REQ_LOAD;
    r.idx = idx;
    r.start = start;
    r.len = len;
    r.kind = kind;
    r.wide = wide;
    r.size = $urandom;
    r.align = $urandom;
    return r;
  endfunction

  function automatic alloc_req_t alloc_item(logic [31:0] size, logic [31:0] align);
    alloc_req_t r;
    r.req = REQ_ALLOC;
    r.idx = 4'($urandom);
    r.start = $urandom;
    r.len = $urandom;
    r.kind = 4'($urandom);
    r.wide = 1'($urandom);
    r.size = size;
    r.align = align;
    return r;
  endfunction

  function automatic alloc_req_t rand_load();
    logic [31:0] start;
    logic [31:0] len;
    logic [3:0]  kind;
    logic        wide;
    int          mode;
    mode = $urandom_range(0, 9);
    if (mode <= 5) begin
      start = free_ptr - $urandom_range(0, 32'h8000);
      len = $urandom_range(32'h8000, 32'h80000);
    end else if (mode <= 7) begin
      start = free_ptr + $urandom_range(0, 32'h40000);
      len = $urandom_range(0, 32'h40000);
    end else if (mode == 8) begin
      start = $urandom;
      len = $urandom;
    end else begin
      start = 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
      len = $urandom_range(0, 32'h20000);
    end
    kind = ($urandom_range(0, 3) != 0) ? KIND_USABLE : 4'($urandom_range(0, 15));
    wide = ($urandom_range(0, 19) == 0);
    return load_item(4'($urandom_range(0, TABLE_DEPTH - 1)), start, len, kind, wide);
  endfunction

  function automatic alloc_req_t rand_alloc();
    logic [31:0] size;
    logic [31:0] align;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick <= 6) size = $urandom_range(0, 32'h800);
    else if (pick <= 8) size = $urandom_range(0, 32'h10000);
    else size = $urandom;
    pick = $urandom_range(0, 19);
    if (pick <= 15) align = 32'd1 << $urandom_range(0, 12);
    else if (pick <= 18) align = 32'd1 << $urandom_range(0, 31);
    else align = $urandom;
    return alloc_item(size, align);
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (request_queue.size() != 0 || s_tvalid || grant_queue.size() != 0);
  endtask

  task automatic write_count(input logic [4:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_mirror = value;
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0s: expected %h got %h", what, want, got);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) model_request(cur_req);
      if (!(s_tvalid && !s_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (request_queue.size() != 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 7) - 1;
            s_tvalid <= 1'b0;
          end else begin
            cur_req = request_queue.pop_front();
            s_tvalid <= 1'b1;
            s_tuser <= cur_req.req;
            s_tdata <= {7'b0, cur_req.align, cur_req.size, cur_req.wide, cur_req.kind,
                        cur_req.len, cur_req.start, cur_req.idx};
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // grant monitor
  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (grant_queue.size() == 0) begin
          note_mismatch("unexpected beat", '0, m_tdata[33:2]);
        end else begin
          want = grant_queue.pop_front();
          if (m_tdata[1:0] != want.status)
            note_mismatch("status", 32'(want.status), 32'(m_tdata[1:0]));
          if (m_tdata[33:2] != want.addr)
            note_mismatch("block_address", want.addr, m_tdata[33:2]);
        end
      end
      if (long_stall_req && !long_stall_done) begin
        long_stall_done = 1'b1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int          loads;
    int          allocs;
    int          pick;
    logic [4:0]  count_pick;
    free_ptr = RESET_FREE;
    count_mirror = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // fill the whole table so no scan ever touches an unloaded entry
    request_queue.push_back(load_item(4'd0, 32'h0, 32'h0, 4'h0, 1'b0));
    request_queue.push_back(load_item(4'd1, 32'h0020_0000, 32'h4000, KIND_USABLE, 1'b0));
    request_queue.push_back(load_item(4'd2, 32'h0030_0000, 32'h10_0000, KIND_USABLE, 1'b0));
    request_queue.push_back(load_item(4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1'b1));
    request_queue.push_back(load_item(4'd4, 32'hFFFF_F000, 32'h2000, KIND_USABLE, 1'b0));
    request_queue.push_back(load_item(4'd5, 32'h0040_0000, 32'h1000, KIND_USABLE, 1'b1));
    for (int i = 6; i < TABLE_DEPTH; i++)
      request_queue.push_back(load_item(4'(i), 32'h0050_0000 + $urandom_range(0, 32'hF_FFFF),
                                        $urandom, KIND_USABLE, 1'b0));
    wait_idle();
    write_count(5'd16);
    request_queue.push_back(alloc_item(32'h0, 32'h1));
    request_queue.push_back(alloc_item(32'h100, 32'h800));
    request_queue.push_back(alloc_item(32'h1800, 32'h10));
    request_queue.push_back(alloc_item(32'h1000, 32'h4));
    request_queue.push_back(alloc_item(32'hFFFF_FFFF, 32'h1));
    request_queue.push_back(alloc_item(32'h10, 32'h8000_0000));
    request_queue.push_back(alloc_item(32'h8, 32'h3));
    request_queue.push_back(alloc_item(32'h8, 32'h0));
    issued = 24;
    wait_idle();
    write_count(5'd0);
    request_queue.push_back(alloc_item(32'h10, 32'h1));
    wait_idle();
    write_count(5'd1);
    request_queue.push_back(alloc_item(32'h10, 32'h1));
    wait_idle();
    write_count(5'd31);
    request_queue.push_back(alloc_item(32'h20, 32'h20));
    wait_idle();
    write_count(5'd6);
    request_queue.push_back(alloc_item(32'h8000_0000, 32'h1));
    issued += 4;
    wait_idle();

    while (issued < ITEM_TARGET) begin
      if ($urandom_range(0, 1) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick <= 4) count_pick = 5'd16;
        else if (pick <= 7) count_pick = 5'($urandom_range(8, 16));
        else count_pick = 5'($urandom_range(0, 31));
        write_count(count_pick);
      end
      if (issued >= 200 && !long_stall_req) long_stall_req = 1'b1;
      if (issued >= CALM_AFTER) calm = 1'b1;
      loads = $urandom_range(1, 6);
      allocs = $urandom_range(10, 30);
      for (int i = 0; i < loads; i++) request_queue.push_back(rand_load());
      for (int i = 0; i < allocs; i++) begin
        if ($urandom_range(0, 9) == 0) request_queue.push_back(rand_load());
        else request_queue.push_back(rand_alloc());
      end
      issued += loads + allocs;
      wait_idle();
    end

    repeat (30) @(posedge clk);
    if (mismatches == 0 && grant_queue.size() == 0) begin
      $display("[region_bump_allocator] OK");
    end else begin
      $display("[region_bump_allocator] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[region_bump_allocator] ERROR");
    $finish;
  end

endmodule
